@@ rtl/core/fwc_pkg.sv @@
`timescale 1ns / 1ps

package fwc_pkg;

  typedef logic [7:0] char_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_STAR  = 8'h2A;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_QMARK = 8'h3F;
  localparam char_t CH_LOW_A = 8'h61;
  localparam char_t CH_LOW_Z = 8'h7A;
  localparam char_t CASE_GAP = 8'h20;

  // slot contents with special meaning
  localparam char_t SLOT_FILL = CH_DOT;
  localparam char_t SLOT_WILD = 8'h00;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_BASE   = 3'd0;
  localparam phase_t PH_AFTER  = 3'd1;
  localparam phase_t PH_EXT    = 3'd2;
  localparam phase_t PH_DONE   = 3'd3;
  localparam phase_t PH_CLOSED = 3'd4;

  // one character step towards a string parser
  typedef struct packed {
    logic  en;
    logic  wild;
    char_t ch;
    logic  last;
  } feed_t;

endpackage

@@ rtl/core/fwc_if.sv @@
`timescale 1ns / 1ps

interface fwc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output req_type, output ch, output last, input ready);
  modport sink (input valid, input req_type, input ch, input last, output ready);
endinterface

interface fwc_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] difference;
  logic              equal;

  modport source (output valid, output difference, output equal, input ready);
  modport sink (input valid, input difference, input equal, output ready);
endinterface

@@ rtl/core/filename_wildcard_compare_top.sv @@
`timescale 1ns / 1ps

// channel    dir  payload                              handshake
// in_chan    in   req_type, ch[7:0], last              valid / ready
// out_chan   out  difference[8:0] signed, equal        valid / ready
//
// one character per cycle while in_chan.ready is high; a pattern's last character gives
// its result through the slot update, then the registered slot compare
// synchronous active-low reset returns both slot rows to '.' filler
// input stalls only while a compare waits and the result register is held

module filename_wildcard_compare_top #(
  parameter int BASE_LEN = 8,
  parameter int EXT_LEN  = 3
) (
  input logic      clk,
  input logic      rst_n,
  fwc_in_if.sink   in_chan,
  fwc_out_if.source out_chan
);

  localparam int SLOTS = BASE_LEN + EXT_LEN;

  logic [SLOTS-1:0][7:0] name_slots;
  logic [SLOTS-1:0][7:0] pattern_slots;
  fwc_pkg::feed_t        name_feed;
  fwc_pkg::feed_t        pattern_feed;

  logic                  accept;
  logic                  load;
  logic                  cmp_pend_r;
  logic                  cmp_pend_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic signed [8:0]     diff_r;
  logic signed [8:0]     diff_nxt;
  logic                  equal_r;
  logic                  equal_nxt;

  assign in_chan.ready = !(cmp_pend_r && out_valid_r && !out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign load          = cmp_pend_r && (!out_valid_r || out_chan.ready);

  always_comb begin
    name_feed.en      = accept && !in_chan.req_type;
    name_feed.wild    = 1'b0;
    name_feed.ch      = in_chan.ch;
    name_feed.last    = in_chan.last;
    pattern_feed.en   = accept && in_chan.req_type;
    pattern_feed.wild = 1'b1;
    pattern_feed.ch   = in_chan.ch;
    pattern_feed.last = in_chan.last;
  end

  fwc_parse #(.BASE_LEN(BASE_LEN), .EXT_LEN(EXT_LEN)) u_name (
    .clk   (clk),
    .rst_n (rst_n),
    .feed  (name_feed),
    .slots (name_slots)
  );

  fwc_parse #(.BASE_LEN(BASE_LEN), .EXT_LEN(EXT_LEN)) u_pattern (
    .clk   (clk),
    .rst_n (rst_n),
    .feed  (pattern_feed),
    .slots (pattern_slots)
  );

  // first non-wildcard mismatch wins, so scan from the top down
  always_comb begin
    diff_nxt  = '0;
    equal_nxt = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pattern_slots[i] != fwc_pkg::SLOT_WILD && pattern_slots[i] != name_slots[i]) begin
        diff_nxt  = {name_slots[i][7], name_slots[i]} - {pattern_slots[i][7], pattern_slots[i]};
        equal_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    cmp_pend_nxt  = (cmp_pend_r && !load) || (accept && in_chan.req_type && in_chan.last);
    out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_pend_r  <= cmp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      diff_r  <= diff_nxt;
      equal_r <= equal_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.difference = diff_r;
  assign out_chan.equal      = equal_r;

endmodule

@@ rtl/core/fwc_parse.sv @@
`timescale 1ns / 1ps

module fwc_parse #(
  parameter int BASE_LEN = 8,
  parameter int EXT_LEN  = 3
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fwc_pkg::feed_t                        feed,
  output logic [BASE_LEN+EXT_LEN-1:0][7:0]      slots
);

  localparam int SLOTS = BASE_LEN + EXT_LEN;
  localparam int MAXL  = (BASE_LEN > EXT_LEN) ? BASE_LEN : EXT_LEN;
  localparam int PW    = $clog2(MAXL + 1);

  typedef struct packed {
    logic [SLOTS-1:0][7:0] s;
    fwc_pkg::phase_t       ph;
    logic [PW-1:0]         pos;
  } pstate_t;

  function automatic pstate_t step(pstate_t st, logic wild, fwc_pkg::char_t c);
    pstate_t        r;
    logic           term;
    logic           endc;
    logic           star;
    logic           qm;
    logic           done;
    fwc_pkg::char_t val;
    int             p;
    r    = st;
    term = (c == fwc_pkg::CH_DOT) || (c == fwc_pkg::CH_SPACE) || (c == fwc_pkg::CH_NUL);
    endc = (c == fwc_pkg::CH_SPACE) || (c == fwc_pkg::CH_NUL);
    star = wild && (c == fwc_pkg::CH_STAR);
    qm   = wild && (c == fwc_pkg::CH_QMARK);
    val  = (c >= fwc_pkg::CH_LOW_A && c <= fwc_pkg::CH_LOW_Z) ? c - fwc_pkg::CASE_GAP : c;
    if (qm) val = fwc_pkg::SLOT_WILD;
    done = 1'b0;
    p    = int'(r.pos);

    if (r.ph == fwc_pkg::PH_BASE) begin
      if (p >= BASE_LEN) begin
        r.ph = fwc_pkg::PH_AFTER;
      end else if (term) begin
        for (int i = 0; i < BASE_LEN; i++) begin
          if (i >= p) r.s[i] = fwc_pkg::SLOT_FILL;
        end
        r.pos = '0;
        if (c == fwc_pkg::CH_DOT) begin
          r.ph = fwc_pkg::PH_EXT;
        end else begin
          for (int i = BASE_LEN; i < SLOTS; i++) r.s[i] = fwc_pkg::SLOT_FILL;
          r.ph = fwc_pkg::PH_DONE;
        end
        done = 1'b1;
      end else if (star) begin
        for (int i = 0; i < BASE_LEN; i++) begin
          if (i >= p) r.s[i] = fwc_pkg::SLOT_WILD;
        end
        r.pos = '0;
        r.ph  = fwc_pkg::PH_AFTER;
        done  = 1'b1;
      end else begin
        for (int i = 0; i < BASE_LEN; i++) begin
          if (i == p) r.s[i] = val;
        end
        if (p + 1 >= BASE_LEN) begin
          r.pos = '0;
          r.ph  = fwc_pkg::PH_AFTER;
        end else begin
          r.pos = r.pos + 1'b1;
        end
        done = 1'b1;
      end
    end

    if (!done && r.ph == fwc_pkg::PH_AFTER) begin
      r.pos = '0;
      if (endc) begin
        for (int i = BASE_LEN; i < SLOTS; i++) r.s[i] = fwc_pkg::SLOT_FILL;
        r.ph = fwc_pkg::PH_DONE;
        done = 1'b1;
      end else begin
        r.ph = fwc_pkg::PH_EXT;
        if (c == fwc_pkg::CH_DOT) done = 1'b1;
      end
    end

    p = int'(r.pos);
    if (!done && r.ph == fwc_pkg::PH_EXT) begin
      if (p >= EXT_LEN) begin
        r.ph = fwc_pkg::PH_DONE;
      end else if (term) begin
        for (int i = BASE_LEN; i < SLOTS; i++) begin
          if (i >= BASE_LEN + p) r.s[i] = fwc_pkg::SLOT_FILL;
        end
        r.ph = fwc_pkg::PH_DONE;
      end else if (star) begin
        for (int i = BASE_LEN; i < SLOTS; i++) begin
          if (i >= BASE_LEN + p) r.s[i] = fwc_pkg::SLOT_WILD;
        end
        r.ph = fwc_pkg::PH_DONE;
      end else begin
        for (int i = BASE_LEN; i < SLOTS; i++) begin
          if (i == BASE_LEN + p) r.s[i] = val;
        end
        r.pos = r.pos + 1'b1;
        if (p + 1 >= EXT_LEN) r.ph = fwc_pkg::PH_DONE;
      end
    end
    return r;
  endfunction

  pstate_t st_r;
  pstate_t st_nxt;
  pstate_t fresh;
  pstate_t st_a;
  pstate_t st_b;
  pstate_t st_c;

  always_comb begin
    fresh.s   = {SLOTS{fwc_pkg::SLOT_FILL}};
    fresh.ph  = fwc_pkg::PH_BASE;
    fresh.pos = '0;
    // a character for a closed string starts that string over
    st_a = (st_r.ph == fwc_pkg::PH_CLOSED) ? fresh : st_r;
    st_b = step(st_a, feed.wild, feed.ch);
    // the final character is followed by an implied terminator
    st_c = step(st_b, feed.wild, fwc_pkg::CH_NUL);
    st_c.ph  = fwc_pkg::PH_CLOSED;
    st_c.pos = '0;
    if (!feed.en) begin
      st_nxt = st_r;
    end else if (feed.last) begin
      st_nxt = st_c;
    end else begin
      st_nxt = st_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fresh;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign slots = st_r.s;

endmodule

@@ bench/tb_filename_wildcard_compare_top.sv @@
`timescale 1ns / 1ps

module tb_filename_wildcard_compare_top;

  localparam int BASE_LEN     = 8;
  localparam int EXT_LEN      = 3;
  localparam int SLOTS        = BASE_LEN + EXT_LEN;
  localparam int NAME_ROW     = 0;
  localparam int PATTERN_ROW  = 1;
  localparam logic REQ_NAME    = 1'b0;
  localparam logic REQ_PATTERN = 1'b1;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_CAP   = 100;

  typedef struct packed {
    logic signed [8:0] difference;
    logic              equal;
  } verdict_t;

  typedef struct packed {
    logic           req_type;
    fwc_pkg::char_t ch;
    logic           last;
    logic           typed;
    verdict_t       verdict;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;

  fwc_in_if  in_chan ();
  fwc_out_if out_chan ();

  filename_wildcard_compare_top #(
    .BASE_LEN(BASE_LEN),
    .EXT_LEN (EXT_LEN)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always #5 clk = ~clk;

  // predicted slot rows, indexed by name / pattern
  fwc_pkg::char_t  slot_row [2][SLOTS];
  fwc_pkg::phase_t row_phase [2];
  int              row_pos [2];

  verdict_t       expected_verdicts [$];
  step_row_t      directed_steps [$];
  fwc_pkg::char_t text_buf [$];
  fwc_pkg::char_t name_text [$];

  int       error_count = 0;
  int       cycle_count = 0;
  int       counted_items = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     typed_on = 1'b0;
  verdict_t typed_verdict = '0;

  function automatic bit is_terminator(input fwc_pkg::char_t c);
    return c == fwc_pkg::CH_DOT || c == fwc_pkg::CH_SPACE || c == fwc_pkg::CH_NUL;
  endfunction

  function automatic fwc_pkg::char_t fold_case(input fwc_pkg::char_t c);
    return (c >= fwc_pkg::CH_LOW_A && c <= fwc_pkg::CH_LOW_Z) ?
           8'(c - fwc_pkg::CASE_GAP) : c;
  endfunction

  function automatic fwc_pkg::char_t slot_value(input logic wild, input fwc_pkg::char_t c);
    return (wild && c == fwc_pkg::CH_QMARK) ? fwc_pkg::SLOT_WILD : fold_case(c);
  endfunction

  function automatic void fill_slots(input int s, input int from, input int upto,
                                     input fwc_pkg::char_t v);
    int i;
    for (i = from; i < upto && i < SLOTS; i++) slot_row[s][i] = v;
  endfunction

  function automatic void clear_row(input int s);
    fill_slots(s, 0, SLOTS, fwc_pkg::SLOT_FILL);
    row_phase[s] = fwc_pkg::PH_BASE;
    row_pos[s] = 0;
  endfunction

  // one character through the 8.3 parser of one row
  function automatic void parse_char(input int s, input fwc_pkg::char_t c);
    logic wild;
    int   idx;
    wild = (s == PATTERN_ROW);
    if (row_phase[s] == fwc_pkg::PH_BASE) begin
      if (row_pos[s] >= BASE_LEN) begin
        row_phase[s] = fwc_pkg::PH_AFTER;
      end else if (is_terminator(c)) begin
        fill_slots(s, row_pos[s], BASE_LEN, fwc_pkg::SLOT_FILL);
        row_pos[s] = 0;
        if (c == fwc_pkg::CH_DOT) begin
          row_phase[s] = fwc_pkg::PH_EXT;
        end else begin
          fill_slots(s, BASE_LEN, SLOTS, fwc_pkg::SLOT_FILL);
          row_phase[s] = fwc_pkg::PH_DONE;
        end
        return;
      end else if (wild && c == fwc_pkg::CH_STAR) begin
        fill_slots(s, row_pos[s], BASE_LEN, fwc_pkg::SLOT_WILD);
        row_pos[s] = 0;
        row_phase[s] = fwc_pkg::PH_AFTER;
        return;
      end else begin
        slot_row[s][row_pos[s]] = slot_value(wild, c);
        row_pos[s]++;
        if (row_pos[s] >= BASE_LEN) begin
          row_pos[s] = 0;
          row_phase[s] = fwc_pkg::PH_AFTER;
        end
        return;
      end
    end
    if (row_phase[s] == fwc_pkg::PH_AFTER) begin
      row_pos[s] = 0;
      if (c == fwc_pkg::CH_SPACE || c == fwc_pkg::CH_NUL) begin
        fill_slots(s, BASE_LEN, SLOTS, fwc_pkg::SLOT_FILL);
        row_phase[s] = fwc_pkg::PH_DONE;
        return;
      end
      row_phase[s] = fwc_pkg::PH_EXT;
      // the dot itself only opens the extension
      if (c == fwc_pkg::CH_DOT) return;
    end
    if (row_phase[s] == fwc_pkg::PH_EXT) begin
      idx = BASE_LEN + row_pos[s];
      if (row_pos[s] >= EXT_LEN) begin
        row_phase[s] = fwc_pkg::PH_DONE;
      end else if (is_terminator(c)) begin
        fill_slots(s, idx, SLOTS, fwc_pkg::SLOT_FILL);
        row_phase[s] = fwc_pkg::PH_DONE;
      end else if (wild && c == fwc_pkg::CH_STAR) begin
        fill_slots(s, idx, SLOTS, fwc_pkg::SLOT_WILD);
        row_phase[s] = fwc_pkg::PH_DONE;
      end else begin
        slot_row[s][idx] = slot_value(wild, c);
        row_pos[s]++;
        if (row_pos[s] >= EXT_LEN) row_phase[s] = fwc_pkg::PH_DONE;
      end
    end
  endfunction

  // updates the rows for one transaction; returns 1 when a verdict is due
  function automatic bit fold_in_char(input logic rt, input fwc_pkg::char_t c,
                                      input logic lst, output verdict_t v);
    int  s;
    int  i;
    int  d;
    byte n_b;
    byte p_b;
    s = (rt == REQ_PATTERN) ? PATTERN_ROW : NAME_ROW;
    v.difference = '0;
    v.equal = 1'b1;
    if (row_phase[s] == fwc_pkg::PH_CLOSED) clear_row(s);
    parse_char(s, c);
    if (!lst) return 1'b0;
    // end of string behaves as a trailing nul
    parse_char(s, fwc_pkg::CH_NUL);
    row_phase[s] = fwc_pkg::PH_CLOSED;
    row_pos[s] = 0;
    if (rt == REQ_NAME) return 1'b0;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_row[PATTERN_ROW][i] != fwc_pkg::SLOT_WILD &&
          slot_row[PATTERN_ROW][i] != slot_row[NAME_ROW][i]) begin
        n_b = slot_row[NAME_ROW][i];
        p_b = slot_row[PATTERN_ROW][i];
        d = n_b - p_b;
        v.difference = d[8:0];
        v.equal = 1'b0;
        break;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < REPORT_CAP)
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
               what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic void add_row(input logic rt, input fwc_pkg::char_t c, input logic lst,
                                  input logic typed, input logic signed [8:0] diff,
                                  input logic eq);
    step_row_t r;
    r.req_type = rt;
    r.ch = c;
    r.last = lst;
    r.typed = typed;
    r.verdict.difference = diff;
    r.verdict.equal = eq;
    directed_steps.push_back(r);
  endfunction

  function automatic fwc_pkg::char_t pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'($urandom_range(fwc_pkg::CH_LOW_A, fwc_pkg::CH_LOW_Z));
    if (r < 55) return 8'($urandom_range(fwc_pkg::CH_LOW_A - fwc_pkg::CASE_GAP,
                                         fwc_pkg::CH_LOW_Z - fwc_pkg::CASE_GAP));
    if (r < 65) return 8'($urandom_range(8'h30, 8'h39));
    if (r < 73) return fwc_pkg::CH_DOT;
    if (r < 77) return fwc_pkg::CH_SPACE;
    if (r < 80) return fwc_pkg::CH_NUL;
    if (r < 84) return ($urandom_range(1) != 0) ? fwc_pkg::CH_QMARK : fwc_pkg::CH_STAR;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_char(input logic rt, input fwc_pkg::char_t c, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.req_type = rt;
    in_chan.ch = c;
    in_chan.last = lst;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input logic rt, input bit close);
    int i;
    for (i = 0; i < text_buf.size(); i++) begin
      send_char(rt, text_buf[i], close && (i == text_buf.size() - 1));
      // characters past a full row are ignored by the parser
      if (i <= SLOTS) counted_items++;
    end
  endtask

  task automatic random_burst();
    int             n;
    int             i;
    int             k;
    int             r;
    fwc_pkg::char_t nc;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 4);
      repeat (n) send_char(1'($urandom_range(1)), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
      counted_items += n;
      return;
    end
    text_buf.delete();
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 16) : $urandom_range(1, 12);
    for (i = 0; i < n; i++) text_buf.push_back(pick_char());
    name_text = text_buf;
    send_text(REQ_NAME, $urandom_range(9) != 0);
    repeat ($urandom_range(1, 3)) begin
      text_buf.delete();
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) text_buf.push_back(pick_char());
      end else begin
        // mostly the name itself, with wildcards, case flips and slips
        for (k = 0; k < name_text.size(); k++) begin
          nc = name_text[k];
          r = $urandom_range(99);
          if (r < 12) begin
            text_buf.push_back(fwc_pkg::CH_QMARK);
          end else if (r < 18) begin
            text_buf.push_back(fwc_pkg::CH_STAR);
            if ($urandom_range(1) != 0) break;
          end else if (r < 30) begin
            if ((nc | fwc_pkg::CASE_GAP) >= fwc_pkg::CH_LOW_A &&
                (nc | fwc_pkg::CASE_GAP) <= fwc_pkg::CH_LOW_Z)
              text_buf.push_back(nc ^ fwc_pkg::CASE_GAP);
            else
              text_buf.push_back(nc);
          end else if (r < 36) begin
            text_buf.push_back(pick_char());
          end else begin
            text_buf.push_back(nc);
          end
        end
      end
      if (text_buf.size() == 0) text_buf.push_back(fwc_pkg::CH_STAR);
      send_text(REQ_PATTERN, $urandom_range(19) != 0);
    end
  endtask

  always @(negedge clk) begin
    out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    verdict_t want;
    verdict_t pred;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("filename_wildcard_compare_top regression: fail");
      $finish;
    end else begin
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result", $signed(out_chan.difference), 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_chan.difference !== want.difference)
            report_mismatch("difference", $signed(out_chan.difference),
                            $signed(want.difference));
          if (out_chan.equal !== want.equal)
            report_mismatch("equal", out_chan.equal, want.equal);
        end
      end
      if (rst_n && in_chan.valid && in_chan.ready) begin
        if (fold_in_char(in_chan.req_type, in_chan.ch, in_chan.last, pred))
          expected_verdicts.push_back(typed_on ? typed_verdict : pred);
      end
    end
  end

  initial begin : stimulus
    int        phase_i;
    int        target;
    int        i;
    step_row_t row;
    clear_row(NAME_ROW);
    clear_row(PATTERN_ROW);
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_NAME;
    in_chan.ch = fwc_pkg::CH_NUL;
    in_chan.last = 1'b0;

    // name never sent: pattern against an all-filler name
    add_row(REQ_PATTERN, 8'h41, 1'b1, 1'b1, -9'sd19, 1'b0);
    add_row(REQ_PATTERN, fwc_pkg::CH_STAR, 1'b1, 1'b1, 9'sd0, 1'b1);
    // signed byte extremes
    add_row(REQ_NAME, 8'h80, 1'b1, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_PATTERN, 8'h7F, 1'b1, 1'b1, -9'sd255, 1'b0);
    add_row(REQ_NAME, 8'h7F, 1'b1, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_PATTERN, 8'h80, 1'b1, 1'b1, 9'sd255, 1'b0);
    // full lower-case base plus pseudo-extension, name left open
    for (i = 0; i < 9; i++)
      add_row(REQ_NAME, 8'(fwc_pkg::CH_LOW_A + i), 1'b0, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_PATTERN, fwc_pkg::CH_STAR, 1'b0, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_PATTERN, 8'h49, 1'b0, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_PATTERN, fwc_pkg::CH_NUL, 1'b1, 1'b0, 9'sd0, 1'b0);
    // nul closes the name, a second nul starts an empty one
    add_row(REQ_NAME, fwc_pkg::CH_NUL, 1'b1, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_NAME, fwc_pkg::CH_NUL, 1'b1, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_PATTERN, 8'hFF, 1'b1, 1'b1, 9'sd47, 1'b0);
    // wildcard characters are plain in the name
    add_row(REQ_NAME, fwc_pkg::CH_QMARK, 1'b0, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_NAME, fwc_pkg::CH_SPACE, 1'b1, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_PATTERN, fwc_pkg::CH_QMARK, 1'b0, 1'b0, 9'sd0, 1'b0);
    add_row(REQ_PATTERN, fwc_pkg::CH_DOT, 1'b1, 1'b0, 9'sd0, 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < directed_steps.size(); i++) begin
      row = directed_steps[i];
      typed_on = row.typed;
      typed_verdict = row.verdict;
      send_char(row.req_type, row.ch, row.last);
    end
    typed_on = 1'b0;

    for (phase_i = 0; phase_i < 4; phase_i++) begin
      case (phase_i)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      target = counted_items + RANDOM_ITEMS / 4;
      while (counted_items < target) random_burst();
    end
    in_chan.valid = 1'b0;

    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("filename_wildcard_compare_top regression: pass");
    else
      $display("filename_wildcard_compare_top regression: fail");
    $finish;
  end

endmodule
